// File: rtl/assert_macros.svh
// Assertion helpers for the checker modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on the rising clock edge and ignored during reset.
`define ASSERT_CLK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Implication form of the same check.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
   `ASSERT_CLK(lbl, (ante) |-> (cons), msg)

`endif

// File: rtl/btps_pkg.sv
package btps_pkg;

   localparam int COORD_BITS     = 12;
   localparam int INTENSITY_BITS = 10;
   localparam int COLOR_BITS     = 27;
   localparam int CSR_DATA_BITS  = (COORD_BITS > INTENSITY_BITS) ? COORD_BITS : INTENSITY_BITS;
   localparam int CSR_INDEX_BITS = 3;
   localparam int AREA_BITS      = 2 * COORD_BITS + 5;
   localparam int MAG_BITS       = AREA_BITS;
   localparam int SCALED_BITS    = MAG_BITS + INTENSITY_BITS;
   localparam int NUM_BITS       = SCALED_BITS + 4;
   localparam int DEN_BITS       = MAG_BITS + 4;
   localparam int Q_BITS         = INTENSITY_BITS + 1;
   localparam int REM_BITS       = NUM_BITS + Q_BITS;
   localparam int PIPE_LATENCY   = Q_BITS + 5;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_VERTEX_A_X  = 3'd0,
      CSR_VERTEX_A_Y  = 3'd1,
      CSR_VERTEX_B_X  = 3'd2,
      CSR_VERTEX_B_Y  = 3'd3,
      CSR_VERTEX_C_X  = 3'd4,
      CSR_VERTEX_C_Y  = 3'd5,
      CSR_INTENSITY   = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] pixel_x;
      logic [COORD_BITS-1:0] pixel_y;
   } req_payload_type;

   typedef struct packed {
      logic                  inside_res;
      logic                  degenerate;
      logic [COLOR_BITS-1:0] pixel_color;
   } rsp_payload_type;

   typedef struct packed {
      logic valid;
      logic in_tri;
      logic degen;
   } ctl_type;

   // One term (q.y - p.y) * (q.x + p.x) of the doubled signed area.
   function automatic logic signed [AREA_BITS-1:0] area_term(
      input logic [COORD_BITS-1:0] p_x,
      input logic [COORD_BITS-1:0] p_y,
      input logic [COORD_BITS-1:0] q_x,
      input logic [COORD_BITS-1:0] q_y
   );
      logic signed [COORD_BITS+1:0]   dif;
      logic signed [COORD_BITS+1:0]   sum;
      logic signed [2*COORD_BITS+3:0] prod;
      dif  = $signed({2'b00, q_y}) - $signed({2'b00, p_y});
      sum  = $signed({2'b00, q_x}) + $signed({2'b00, p_x});
      prod = dif * sum;
      return AREA_BITS'(prod);
   endfunction

   function automatic logic [MAG_BITS-1:0] area_mag(input logic signed [AREA_BITS-1:0] v);
      return v[AREA_BITS-1] ? MAG_BITS'(-v) : MAG_BITS'(v);
   endfunction

endpackage

// File: rtl/barycentric_triangle_pixel_shader.sv
// Each accepted start reaches the result strobe through the s1, s2, s3, divider and output registers.
// Throughput: one transaction per cycle; busy is always low.
// The quotient is formed by an 11-stage restoring divider, one bit per stage.
// Synchronous active-high reset clears the CSR registers and all valid bits, not the datapath registers.
// The receiver cannot stall; results are never held.
module barycentric_triangle_pixel_shader (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  btps_pkg::req_payload_type             req_data,
   input  logic                                  csr_we,
   input  logic [btps_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [btps_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   output logic                                  rsp_valid,
   output btps_pkg::rsp_payload_type             rsp_data
);
   import btps_pkg::*;

   logic [COORD_BITS-1:0]     ax_ff, ay_ff, bx_ff, by_ff, cx_ff, cy_ff;
   logic [INTENSITY_BITS-1:0] inten_ff;

   logic signed [AREA_BITS-1:0] t_ff;
   logic                        t_neg_ff, t_zero_ff;
   logic [DEN_BITS-1:0]         den_ff;

   ctl_type                     s1_ctl_ff, s2_ctl_ff, s3_ctl_ff;
   logic signed [AREA_BITS-1:0] prod_ff [3][3];
   logic signed [AREA_BITS-1:0] w_ff [3];
   logic [SCALED_BITS-1:0]      scaled_ff [3];
   logic                        s3_in;

   ctl_type               div_ctl_ff [Q_BITS+1];
   logic [REM_BITS-1:0]   rem_ff [Q_BITS+1][3];
   logic [Q_BITS-1:0]     quo_ff [Q_BITS+1][3];

   ctl_type               out_ctl_ff;
   logic [COLOR_BITS-1:0] color_ff;
   logic [COLOR_BITS-1:0] color_in;

   logic [COORD_BITS-1:0] px, py;

   assign busy = 1'b0;
   assign px   = req_data.pixel_x;
   assign py   = req_data.pixel_y;

   always_ff @(posedge clock) begin
      if (reset) begin
         ax_ff <= '0; ay_ff <= '0; bx_ff <= '0;
         by_ff <= '0; cx_ff <= '0; cy_ff <= '0;
         inten_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_VERTEX_A_X: ax_ff <= csr_wdata[COORD_BITS-1:0];
            CSR_VERTEX_A_Y: ay_ff <= csr_wdata[COORD_BITS-1:0];
            CSR_VERTEX_B_X: bx_ff <= csr_wdata[COORD_BITS-1:0];
            CSR_VERTEX_B_Y: by_ff <= csr_wdata[COORD_BITS-1:0];
            CSR_VERTEX_C_X: cx_ff <= csr_wdata[COORD_BITS-1:0];
            CSR_VERTEX_C_Y: cy_ff <= csr_wdata[COORD_BITS-1:0];
            CSR_INTENSITY:  inten_ff <= csr_wdata[INTENSITY_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      t_ff      <= area_term(ax_ff, ay_ff, bx_ff, by_ff) + area_term(bx_ff, by_ff, cx_ff, cy_ff)
                 + area_term(cx_ff, cy_ff, ax_ff, ay_ff);
      t_neg_ff  <= t_ff[AREA_BITS-1];
      t_zero_ff <= (t_ff == '0);
      den_ff    <= DEN_BITS'(area_mag(t_ff)) * DEN_BITS'(10);
   end

   always_comb begin
      s3_in = !t_zero_ff;
      for (int k = 0; k < 3; k++) begin
         if (w_ff[k] != '0 && (w_ff[k][AREA_BITS-1] != t_neg_ff)) begin
            s3_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff  <= '0;
         s2_ctl_ff  <= '0;
         s3_ctl_ff  <= '0;
         out_ctl_ff <= '0;
         for (int s = 0; s <= Q_BITS; s++) begin
            div_ctl_ff[s] <= '0;
         end
      end else begin
         s1_ctl_ff     <= '{valid: start && !busy, in_tri: 1'b0, degen: 1'b0};
         s2_ctl_ff     <= s1_ctl_ff;
         s3_ctl_ff     <= '{valid: s2_ctl_ff.valid, in_tri: s3_in, degen: t_zero_ff};
         div_ctl_ff[0] <= s3_ctl_ff;
         for (int s = 0; s < Q_BITS; s++) begin
            div_ctl_ff[s+1] <= div_ctl_ff[s];
         end
         out_ctl_ff <= div_ctl_ff[Q_BITS];
      end
   end

   always_ff @(posedge clock) begin
      prod_ff[0][0] <= area_term(px, py, bx_ff, by_ff);
      prod_ff[0][1] <= area_term(bx_ff, by_ff, cx_ff, cy_ff);
      prod_ff[0][2] <= area_term(cx_ff, cy_ff, px, py);
      prod_ff[1][0] <= area_term(px, py, cx_ff, cy_ff);
      prod_ff[1][1] <= area_term(cx_ff, cy_ff, ax_ff, ay_ff);
      prod_ff[1][2] <= area_term(ax_ff, ay_ff, px, py);
      prod_ff[2][0] <= area_term(px, py, ax_ff, ay_ff);
      prod_ff[2][1] <= area_term(ax_ff, ay_ff, bx_ff, by_ff);
      prod_ff[2][2] <= area_term(bx_ff, by_ff, px, py);
      for (int k = 0; k < 3; k++) begin
         w_ff[k]      <= prod_ff[k][0] + prod_ff[k][1] + prod_ff[k][2];
         scaled_ff[k] <= SCALED_BITS'(area_mag(w_ff[k])) * SCALED_BITS'(inten_ff);
         rem_ff[0][k] <= REM_BITS'({scaled_ff[k], 3'b000}) + REM_BITS'({scaled_ff[k], 1'b0})
                       + REM_BITS'(scaled_ff[k]);
         quo_ff[0][k] <= '0;
      end
      for (int s = 0; s < Q_BITS; s++) begin
         for (int k = 0; k < 3; k++) begin
            if (rem_ff[s][k] >= (REM_BITS'(den_ff) << (Q_BITS - 1 - s))) begin
               rem_ff[s+1][k] <= rem_ff[s][k] - (REM_BITS'(den_ff) << (Q_BITS - 1 - s));
               quo_ff[s+1][k] <= {quo_ff[s][k][Q_BITS-2:0], 1'b1};
            end else begin
               rem_ff[s+1][k] <= rem_ff[s][k];
               quo_ff[s+1][k] <= {quo_ff[s][k][Q_BITS-2:0], 1'b0};
            end
         end
      end
      color_ff <= color_in;
   end

   always_comb begin
      color_in = (COLOR_BITS'(quo_ff[Q_BITS][0]) << 16) ^ (COLOR_BITS'(quo_ff[Q_BITS][1]) << 8)
               ^ COLOR_BITS'(quo_ff[Q_BITS][2]);
      if (!div_ctl_ff[Q_BITS].in_tri) begin
         color_in = '0;
      end
   end

   assign rsp_valid            = out_ctl_ff.valid;
   assign rsp_data.inside_res  = out_ctl_ff.in_tri;
   assign rsp_data.degenerate  = out_ctl_ff.degen;
   assign rsp_data.pixel_color = color_ff;

endmodule

// File: rtl/btps_checker.sv
`include "assert_macros.svh"

module btps_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       start,
   input logic                       busy,
   input logic                       rsp_valid,
   input btps_pkg::rsp_payload_type  rsp_data
);
   import btps_pkg::*;

   `ASSERT_IMPLIES(a_rsp_follows, start && !busy, ##PIPE_LATENCY rsp_valid, "missing result")
   `ASSERT_IMPLIES(a_no_extra, !(start && !busy), ##PIPE_LATENCY !rsp_valid, "unexpected result")
   `ASSERT_IMPLIES(a_degen_out, rsp_valid && rsp_data.degenerate, !rsp_data.inside_res, "degenerate inside")
   `ASSERT_IMPLIES(a_color_zero, rsp_valid && !rsp_data.inside_res, rsp_data.pixel_color == '0, "color not cleared")

endmodule

bind barycentric_triangle_pixel_shader btps_checker u_btps_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

// File: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import btps_pkg::*;

   class shade_scoreboard;
      logic [COORD_BITS-1:0]     ax, ay, bx, by, cx, cy;
      logic [INTENSITY_BITS-1:0] level;
      rsp_payload_type           pending[$];
      int                        errors;

      function new();
         errors = 0;
         reset_regs();
      endfunction

      function void reset_regs();
         ax = '0; ay = '0; bx = '0; by = '0; cx = '0; cy = '0; level = '0;
      endfunction

      function void write_reg(csr_index_type idx, logic [CSR_DATA_BITS-1:0] val);
         case (idx)
            CSR_VERTEX_A_X: ax = val[COORD_BITS-1:0];
            CSR_VERTEX_A_Y: ay = val[COORD_BITS-1:0];
            CSR_VERTEX_B_X: bx = val[COORD_BITS-1:0];
            CSR_VERTEX_B_Y: by = val[COORD_BITS-1:0];
            CSR_VERTEX_C_X: cx = val[COORD_BITS-1:0];
            CSR_VERTEX_C_Y: cy = val[COORD_BITS-1:0];
            CSR_INTENSITY:  level = val[INTENSITY_BITS-1:0];
            default: ;
         endcase
      endfunction

      function longint doubled_area(longint px, longint py, longint qx, longint qy,
                                    longint rx, longint ry);
         return (qy - py) * (qx + px) + (ry - qy) * (rx + qx) + (py - ry) * (px + rx);
      endfunction

      function longint shade(longint w, longint t);
         longint mw, mt;
         mw = (w < 0) ? -w : w;
         mt = (t < 0) ? -t : t;
         return (11 * mw * longint'(level)) / (10 * mt);
      endfunction

      function bit weight_negative(longint w, longint t);
         return (w != 0) && ((w < 0) != (t < 0));
      endfunction

      function void note_pixel(req_payload_type px_in);
         rsp_payload_type e;
         longint px, py, t, wa, wb, wc;
         logic [63:0] col;
         px = px_in.pixel_x;
         py = px_in.pixel_y;
         e = '0;
         t = doubled_area(ax, ay, bx, by, cx, cy);
         if (t == 0) begin
            e.degenerate = 1'b1;
         end else begin
            wa = doubled_area(px, py, bx, by, cx, cy);
            wb = doubled_area(px, py, cx, cy, ax, ay);
            wc = doubled_area(px, py, ax, ay, bx, by);
            if (!weight_negative(wa, t) && !weight_negative(wb, t) &&
                !weight_negative(wc, t)) begin
               col = (shade(wa, t) << 16) ^ (shade(wb, t) << 8) ^ shade(wc, t);
               e.inside_res = 1'b1;
               e.pixel_color = col[COLOR_BITS-1:0];
            end
         end
         pending.push_back(e);
      endfunction

      function void check_result(rsp_payload_type got);
         rsp_payload_type e;
         if (pending.size() == 0) begin
            $error("result with no pixel outstanding");
            errors++;
            return;
         end
         e = pending.pop_front();
         if (got.inside_res !== e.inside_res) begin
            $error("inside_res expected %0d actual %0d", e.inside_res, got.inside_res);
            errors++;
         end
         if (got.degenerate !== e.degenerate) begin
            $error("degenerate expected %0d actual %0d", e.degenerate, got.degenerate);
            errors++;
         end
         if (got.pixel_color !== e.pixel_color) begin
            $error("pixel_color expected %h actual %h", e.pixel_color, got.pixel_color);
            errors++;
         end
      endfunction
   endclass

   localparam int WATCHDOG_LIMIT = 2000;

   logic                        clock;
   logic                        reset;
   logic                        start;
   logic                        busy;
   req_payload_type             req_data;
   logic                        csr_we;
   logic [CSR_INDEX_BITS-1:0]   csr_index;
   logic [CSR_DATA_BITS-1:0]    csr_wdata;
   logic                        rsp_valid;
   rsp_payload_type             rsp_data;

   shade_scoreboard             board;
   int                          quiet_cycles;
   bit                          no_gaps;

   barycentric_triangle_pixel_shader DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      quiet_cycles = 0;
      no_gaps = 1'b0;
      board = new();
   end

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) begin
            board.check_result(rsp_data);
         end
         if ((start && !busy) || rsp_valid) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[barycentric_triangle_pixel_shader] ERROR");
            $finish;
         end
      end
   end

   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_BITS-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      board.write_reg(idx, val);
      csr_we <= 1'b0;
   endtask

   task automatic set_triangle(int x0, int y0, int x1, int y1, int x2, int y2, int lvl);
      write_reg(CSR_VERTEX_A_X, CSR_DATA_BITS'(x0));
      write_reg(CSR_VERTEX_A_Y, CSR_DATA_BITS'(y0));
      write_reg(CSR_VERTEX_B_X, CSR_DATA_BITS'(x1));
      write_reg(CSR_VERTEX_B_Y, CSR_DATA_BITS'(y1));
      write_reg(CSR_VERTEX_C_X, CSR_DATA_BITS'(x2));
      write_reg(CSR_VERTEX_C_Y, CSR_DATA_BITS'(y2));
      write_reg(CSR_INTENSITY, CSR_DATA_BITS'(lvl));
   endtask

   task automatic send_pixel(int x, int y);
      int gap;
      if (!no_gaps && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         gap = $urandom_range(1, 10);
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_data.pixel_x <= COORD_BITS'(x);
      req_data.pixel_y <= COORD_BITS'(y);
      @(posedge clock);
      while (busy) @(posedge clock);
      board.note_pixel(req_data);
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 4) @(posedge clock);
   endtask

   task automatic random_pixel(int x0, int y0, int x1, int y1, int x2, int y2);
      int lo_x, hi_x, lo_y, hi_y;
      if ($urandom_range(0, 3) == 0) begin
         send_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
      end else begin
         lo_x = (x0 < x1) ? x0 : x1; lo_x = (lo_x < x2) ? lo_x : x2;
         hi_x = (x0 > x1) ? x0 : x1; hi_x = (hi_x > x2) ? hi_x : x2;
         lo_y = (y0 < y1) ? y0 : y1; lo_y = (lo_y < y2) ? lo_y : y2;
         hi_y = (y0 > y1) ? y0 : y1; hi_y = (hi_y > y2) ? hi_y : y2;
         send_pixel($urandom_range(lo_x, hi_x), $urandom_range(lo_y, hi_y));
      end
   endtask

   initial begin
      int v[6];
      int lvl;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_pixel(0, 0);
      send_pixel(4095, 4095);
      drain();

      set_triangle(0, 0, 4095, 0, 0, 4095, 1023);
      send_pixel(0, 0);
      send_pixel(4095, 0);
      send_pixel(0, 4095);
      send_pixel(2047, 2048);
      send_pixel(2048, 2048);
      send_pixel(4095, 4095);
      send_pixel(1000, 1000);
      send_pixel(1365, 1365);
      drain();

      set_triangle(0, 0, 0, 4095, 4095, 0, 1023);
      send_pixel(1365, 1365);
      send_pixel(0, 2000);
      send_pixel(4095, 4095);
      send_pixel(100, 3000);
      drain();

      set_triangle(10, 10, 20, 20, 30, 30, 500);
      send_pixel(20, 20);
      send_pixel(5, 7);
      drain();

      set_triangle(0, 0, 4095, 4095, 4095, 0, 0);
      send_pixel(3000, 1000);
      send_pixel(4095, 0);
      drain();

      set_triangle(0, 0, 2, 0, 0, 2, 1023);
      send_pixel(0, 0);
      send_pixel(1, 1);
      send_pixel(1, 0);
      drain();

      for (int phase = 0; phase < 25; phase++) begin
         foreach (v[i]) begin
            v[i] = (phase % 4 == 0) ? $urandom_range(0, 63) : $urandom_range(0, 4095);
         end
         case (phase % 5)
            0: lvl = 1023;
            1: lvl = 0;
            default: lvl = $urandom_range(0, 1023);
         endcase
         if (phase == 7) begin
            v[4] = v[0]; v[5] = v[1];
         end
         set_triangle(v[0], v[1], v[2], v[3], v[4], v[5], lvl);
         no_gaps = (phase >= 21);
         for (int n = 0; n < 50; n++) begin
            random_pixel(v[0], v[1], v[2], v[3], v[4], v[5]);
         end
         drain();
      end

      if (board.errors == 0) begin
         $display("[barycentric_triangle_pixel_shader] OK");
      end else begin
         $display("[barycentric_triangle_pixel_shader] ERROR");
      end
      $finish;
   end

endmodule
